// File: src/tse_pkg.sv
`timescale 1ns / 1ps

package tse_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = VTX_W + 1;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_SORT     = 1'b1;

    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    localparam logic [1:0] EDGE_OK      = 2'd0;
    localparam logic [1:0] EDGE_REVERSE = 2'd1;
    localparam logic [1:0] EDGE_RANGE   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EDGE,
        ST_COUNT,
        ST_QINIT,
        ST_CHECK,
        ST_POP,
        ST_LOAD,
        ST_SCAN,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic load_input;
        logic edge_load;
        logic count_step;
        logic qinit_step;
        logic pop_read;
        logic load_k;
        logic scan_step;
        logic emit_vertex;
        logic emit_empty;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_sort;
        logic n_zero;
        logic idx_last;
        logic tail_zero;
        logic queue_empty;
        logic out_free;
    } ctrl_status_t;

endpackage

// File: src/tse_ram.sv
`timescale 1ns / 1ps

module tse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// File: src/tse_datapath.sv
`timescale 1ns / 1ps

module tse_datapath
    import tse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [CNT_W-1:0]   cfg_data,
    input  logic               command,
    input  logic [VTX_W-1:0]   src_vertex,
    input  logic [VTX_W-1:0]   dst_vertex,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               result_kind,
    output logic [1:0]         edge_status,
    output logic [VTX_W-1:0]   vertex_index,
    output logic               vertex_valid,
    output logic               last,
    output logic               complete,
    input  ctrl_cmd_t          cmd,
    output ctrl_status_t       status
);

    logic [CNT_W-1:0]        vc_reg;
    logic [CNT_W-1:0]        n_active;
    logic [MAX_VERTICES-1:0] adj_reg [MAX_VERTICES];
    logic [CNT_W-1:0]        indeg_reg [MAX_VERTICES];
    logic                    cmd_reg;
    logic [VTX_W-1:0]        src_reg;
    logic [VTX_W-1:0]        dst_reg;
    logic [VTX_W-1:0]        idx_reg;
    logic [VTX_W-1:0]        k_reg;
    logic [CNT_W-1:0]        head_reg;
    logic [CNT_W-1:0]        tail_reg;
    logic [CNT_W-1:0]        emitted_reg;
    logic                    out_valid_reg;
    logic                    kind_reg;
    logic [1:0]              status_reg;
    logic [VTX_W-1:0]        vidx_reg;
    logic                    vvalid_reg;
    logic                    last_reg;
    logic                    complete_reg;

    logic [1:0]       edge_code;
    logic             cur_bit;
    logic [CNT_W-1:0] cur_deg;
    logic             dec_zero;
    logic             q_wr;
    logic [VTX_W-1:0] q_rdata;
    logic             step;
    logic             queue_empty;
    logic             out_free;

    assign n_active = (vc_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vc_reg;

    always_comb
    begin
        if ({1'b0, src_reg} >= n_active || {1'b0, dst_reg} >= n_active)
        begin
            edge_code = EDGE_RANGE;
        end
        else if (adj_reg[dst_reg][src_reg])
        begin
            edge_code = EDGE_REVERSE;
        end
        else
        begin
            edge_code = EDGE_OK;
        end
    end

    assign cur_bit     = adj_reg[k_reg][idx_reg];
    assign cur_deg     = indeg_reg[idx_reg];
    assign dec_zero    = cur_bit && (cur_deg == CNT_W'(1));
    assign q_wr        = (cmd.qinit_step && cur_deg == '0) || (cmd.scan_step && dec_zero);
    assign step        = cmd.count_step || cmd.qinit_step || cmd.scan_step;
    assign queue_empty = (head_reg == tail_reg);
    assign out_free    = !out_valid_reg || out_ready;

    assign status.is_sort     = (cmd_reg == CMD_SORT);
    assign status.n_zero      = (n_active == '0);
    assign status.idx_last    = (CNT_W'(idx_reg) + CNT_W'(1) == n_active);
    assign status.tail_zero   = (tail_reg == '0);
    assign status.queue_empty = queue_empty;
    assign status.out_free    = out_free;

    tse_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_queue (
        .clk     (clk),
        .wr_en   (q_wr),
        .wr_addr (tail_reg[VTX_W-1:0]),
        .wr_data (idx_reg),
        .rd_en   (cmd.pop_read),
        .rd_addr (head_reg[VTX_W-1:0]),
        .rd_data (q_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= CNT_W'(MAX_VERTICES);
            for (int r = 0; r < MAX_VERTICES; r++)
            begin
                adj_reg[r] <= '0;
            end
            idx_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                vc_reg <= cfg_data;
            end

            if (cmd.load_input)
            begin
                idx_reg     <= '0;
                head_reg    <= '0;
                tail_reg    <= '0;
                emitted_reg <= '0;
            end

            if (step)
            begin
                idx_reg <= status.idx_last ? '0 : idx_reg + VTX_W'(1);
            end

            if (q_wr)
            begin
                tail_reg <= tail_reg + CNT_W'(1);
            end

            if (cmd.load_k)
            begin
                head_reg <= head_reg + CNT_W'(1);
            end

            if (cmd.edge_load && edge_code == EDGE_OK)
            begin
                adj_reg[src_reg][dst_reg] <= 1'b1;
            end

            // visited edges stay cleared after the sort
            if (cmd.scan_step && cur_bit)
            begin
                adj_reg[k_reg][idx_reg] <= 1'b0;
            end

            if (cmd.emit_vertex)
            begin
                emitted_reg <= emitted_reg + CNT_W'(1);
            end

            if (cmd.edge_load || cmd.emit_vertex || cmd.emit_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_input)
        begin
            cmd_reg <= command;
            src_reg <= src_vertex;
            dst_reg <= dst_vertex;
            for (int j = 0; j < MAX_VERTICES; j++)
            begin
                indeg_reg[j] <= '0;
            end
        end
        else if (cmd.count_step)
        begin
            // add one row of edge bits into every column count
            for (int j = 0; j < MAX_VERTICES; j++)
            begin
                indeg_reg[j] <= indeg_reg[j] + CNT_W'(adj_reg[idx_reg][j]);
            end
        end
        else if (cmd.scan_step && cur_bit && cur_deg != '0)
        begin
            indeg_reg[idx_reg] <= cur_deg - CNT_W'(1);
        end

        if (cmd.load_k)
        begin
            k_reg <= q_rdata;
        end

        if (cmd.edge_load)
        begin
            kind_reg     <= KIND_EDGE;
            status_reg   <= edge_code;
            vidx_reg     <= '0;
            vvalid_reg   <= 1'b0;
            last_reg     <= 1'b1;
            complete_reg <= 1'b0;
        end
        else if (cmd.emit_vertex)
        begin
            kind_reg     <= KIND_VERTEX;
            status_reg   <= EDGE_OK;
            vidx_reg     <= k_reg;
            vvalid_reg   <= 1'b1;
            last_reg     <= queue_empty;
            complete_reg <= queue_empty && (emitted_reg + CNT_W'(1) == n_active);
        end
        else if (cmd.emit_empty)
        begin
            kind_reg     <= KIND_VERTEX;
            status_reg   <= EDGE_OK;
            vidx_reg     <= '0;
            vvalid_reg   <= 1'b0;
            last_reg     <= 1'b1;
            complete_reg <= (n_active == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign edge_status  = status_reg;
    assign vertex_index = vidx_reg;
    assign vertex_valid = vvalid_reg;
    assign last         = last_reg;
    assign complete     = complete_reg;

endmodule

// File: src/tse_controller.sv
`timescale 1ns / 1ps

module tse_controller
    import tse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (!status.is_sort)
                begin
                    state_next = ST_EDGE;
                end
                else if (status.n_zero)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_EDGE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COUNT:
            begin
                if (status.idx_last)
                begin
                    state_next = ST_QINIT;
                end
            end
            ST_QINIT:
            begin
                if (status.idx_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.tail_zero ? ST_EMPTY : ST_POP;
            end
            ST_POP:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.idx_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.queue_empty ? ST_IDLE : ST_POP;
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load_input = in_valid;
            end
            ST_EDGE:   cmd.edge_load   = status.out_free;
            ST_COUNT:  cmd.count_step  = 1'b1;
            ST_QINIT:  cmd.qinit_step  = 1'b1;
            ST_POP:    cmd.pop_read    = 1'b1;
            ST_LOAD:   cmd.load_k      = 1'b1;
            ST_SCAN:   cmd.scan_step   = 1'b1;
            ST_EMIT:   cmd.emit_vertex = status.out_free;
            ST_EMPTY:  cmd.emit_empty  = status.out_free;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: src/topological_sort_engine_top.sv
`timescale 1ns / 1ps

// Topological sort engine on a 32 x 32 bit adjacency matrix held in flip-flops
// (cleared by reset). An add-edge word returns one status word, registered in
// the edge state after the dispatch state. A sort word walks the matrix row by
// row: the count state adds each row into all in-degrees, the queue-init state
// queues the zero-degree vertices, then per emitted vertex one read of the
// ready-queue RAM plus a scan of its row; the output side may hold any word.
// One word is worked on at a time; the next input is taken once the last
// result is registered. The user writes vertex_count through the cfg channel
// only while the block is idle; the block itself does not enforce this.

module topological_sort_engine_top
    import tse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             command,
    input  logic [VTX_W-1:0] src_vertex,
    input  logic [VTX_W-1:0] dst_vertex,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             result_kind,
    output logic [1:0]       edge_status,
    output logic [VTX_W-1:0] vertex_index,
    output logic             vertex_valid,
    output logic             last,
    output logic             complete
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    tse_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tse_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .command      (command),
        .src_vertex   (src_vertex),
        .dst_vertex   (dst_vertex),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .result_kind  (result_kind),
        .edge_status  (edge_status),
        .vertex_index (vertex_index),
        .vertex_valid (vertex_valid),
        .last         (last),
        .complete     (complete),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
